// ===== rtl/core/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 to code point decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package u8d_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned BYTE_W = 8;

    // Lead byte classification masks and tags
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    // Payload masks
    localparam logic [7:0] PAY2_MASK = 8'h1F;
    localparam logic [7:0] PAY3_MASK = 8'h0F;
    localparam logic [7:0] PAY4_MASK = 8'h07;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // Continuation counts loaded by a lead byte
    localparam logic [1:0] REM_NONE = 2'd0;
    localparam logic [1:0] REM_ONE  = 2'd1;
    localparam logic [1:0] REM_TWO  = 2'd2;
    localparam logic [1:0] REM_THREE = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0] acc;
        logic [1:0]      rem;
    } t_state;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] cp;
        logic            has;
        logic            eos;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/u8d_step.sv =====
// Per-byte decode step: next decoder state and the optional result.
// Depends on u8d_pkg.
`default_nettype none

module u8d_step
    import u8d_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_final,
    input  wire t_state            i_state,
    output t_state                 o_state_next,
    output t_result                o_result
);

    logic [CP_W-1:0]   acc_sh;
    logic [CP_W-1:0]   cp;
    logic              produced;
    logic              lead_ok;
    t_state            n_state;
    logic [BYTE_W-1:0] cont_bits;

    assign cont_bits = i_byte & CONT_MASK;
    assign acc_sh    = {i_state.acc[CP_W-7:0], cont_bits[5:0]};

    always_comb begin
        n_state  = i_state;
        produced = 1'b0;
        lead_ok  = 1'b1;
        cp       = '0;

        if (i_state.rem != REM_NONE) begin
            // inside a sequence: take any byte as continuation
            n_state.rem = i_state.rem - 2'd1;
            if (i_state.rem == REM_ONE) begin
                cp          = acc_sh;
                produced    = 1'b1;
                n_state.acc = '0;
            end else begin
                n_state.acc = acc_sh;
            end
        end else if (!i_byte[7]) begin
            cp       = {{(CP_W-BYTE_W){1'b0}}, i_byte};
            produced = 1'b1;
        end else if ((i_byte & LEAD2_MASK) == LEAD2_TAG) begin
            n_state.acc = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY2_MASK};
            n_state.rem = REM_ONE;
        end else if ((i_byte & LEAD3_MASK) == LEAD3_TAG) begin
            n_state.acc = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY3_MASK};
            n_state.rem = REM_TWO;
        end else if ((i_byte & LEAD4_MASK) == LEAD4_TAG) begin
            n_state.acc = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY4_MASK};
            n_state.rem = REM_THREE;
        end else begin
            lead_ok = 1'b0;
        end

        if (i_final) begin
            // report an open sequence as it stands, then return to reset
            if (!produced && lead_ok) begin
                cp       = n_state.acc;
                produced = 1'b1;
            end
            n_state = '0;
        end

        o_state_next  = n_state;
        o_result.emit = produced | i_final;
        o_result.cp   = cp;
        o_result.has  = produced;
        o_result.eos  = i_final;
    end

endmodule

`default_nettype wire

// ===== rtl/core/u8d_out_reg.sv =====
// Result register of the decoder: holds one result until the sink takes it.
// Depends on u8d_pkg.
`default_nettype none

module u8d_out_reg
    import u8d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_code_point_decoder.sv =====
// Top level of the lenient UTF-8 to code point decoder.
// Depends on u8d_pkg, u8d_step and u8d_out_reg.
//
// Usage:
//   Slave channel (s_axis) takes one request per byte: tdata is the raw byte,
//   tlast marks the last byte of the string. Master channel (m_axis) gives
//   zero or one request per byte: tdata[20:0] is the code point, tuser[0]
//   says the code point is valid, tlast flags the result of the final byte.
//   Lead bytes and invalid lead bytes that are not final give no result.
// Path: an accepted byte goes through the input register, then the result
//   register, to m_axis. Throughput: one byte per cycle while the sink does
//   not stall; the only state carried between bytes is the accumulator and
//   the count, updated in one pass of the step logic.
// Reset: synchronous, active low; clears both registers' valid flags and the
//   decoder state, so the next byte starts outside any sequence.
// Stall: while the sink holds tready low the result register holds; a byte
//   that gives no result still moves on, and the input register refills in
//   the cycle the result register frees.
`default_nettype none

module utf8_to_code_point_decoder
    import u8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [7:0] byte_value
    input  wire logic        i_s_axis_tlast,  // is_final_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // [20:0] code_point, [23:21] zero
    output logic [0:0]       o_m_axis_tuser,  // [0] has_code_point
    output logic             o_m_axis_tlast   // end_of_string
);

    // input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_final;

    // decoder state
    t_state  r_state;
    t_state  n_state;

    t_result step_result;
    t_result out_result;
    logic    out_valid;
    logic    s1_advance;
    logic    out_load;
    logic    s_accept;

    u8d_step u_step (
        .i_byte       (r_s1_byte),
        .i_final      (r_s1_final),
        .i_state      (r_state),
        .o_state_next (n_state),
        .o_result     (step_result)
    );

    // advance when there is no result to place or the result register frees
    assign s1_advance = r_s1_valid &&
                        (!step_result.emit || !out_valid || i_m_axis_tready);
    assign out_load   = s1_advance && step_result.emit;

    assign o_s_axis_tready = !r_s1_valid || s1_advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_state <= n_state;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_byte  <= i_s_axis_tdata;
            r_s1_final <= i_s_axis_tlast;
        end
    end

    u8d_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (step_result),
        .i_ready  (i_m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {3'b000, out_result.cp};
    assign o_m_axis_tuser  = out_result.has;
    assign o_m_axis_tlast  = out_result.eos;

    // final byte returns the decoder to its reset state
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && r_s1_final |=> (r_state.rem == REM_NONE) && (r_state.acc == '0))
        else $error("decoder state not cleared after final byte");

    // a completed sequence leaves an empty accumulator
    a_complete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && (r_state.rem == REM_ONE) |=> r_state.acc == '0)
        else $error("accumulator not cleared after completed sequence");

    // results not at end of string always carry a code point
    a_nonfinal_has_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser[0])
        else $error("non-final result without code point");

    // an empty result occurs only at end of string, with zero data
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("empty result malformed");

    // outside a sequence the accumulator is empty
    a_idle_acc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.rem == REM_NONE |-> r_state.acc == '0)
        else $error("accumulator nonzero outside a sequence");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for utf8_to_code_point_decoder: drives byte strings on the slave
// stream, predicts each code point result, and checks the master stream.
// Depends on u8d_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module testbench;
    import u8d_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 1525;
    localparam int MAX_GAP      = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            has;
        logic            eos;
    } t_cp_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // Decoder state as the predictor sees it.
    logic [CP_W-1:0] seq_acc  = '0;
    logic [1:0]      seq_left = REM_NONE;

    t_cp_result pending_code_points[$];
    logic [7:0] text_bytes[$];

    int  mismatch_count = 0;
    int  bytes_sent     = 0;
    bit  send_gaps_on   = 1'b1;
    bit  recv_stalls_on = 1'b1;

    always #5 i_clk = ~i_clk;

    utf8_to_code_point_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] byte_value
        .i_s_axis_tlast  (s_tlast),   // is_final_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [20:0] code_point, [23:21] zero
        .o_m_axis_tuser  (m_tuser),   // [0] has_code_point
        .o_m_axis_tlast  (m_tlast)    // end_of_string
    );

    // Append one prediction at the tail of the expected-result queue.
    function automatic void queue_result(input t_cp_result r);
        pending_code_points.insert(pending_code_points.size(), r);
    endfunction

    // Append one byte at the tail of the string being built.
    function automatic void append_text_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    // Advance the decoder state by one byte and queue the result it causes.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [CP_W-1:0] cp;
        logic            produced;
        logic            lead_ok;
        cp       = '0;
        produced = 1'b0;
        lead_ok  = 1'b1;
        if (seq_left != REM_NONE) begin
            // inside a sequence: take any byte as a continuation, marker unchecked
            seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == REM_NONE) begin
                cp       = seq_acc;
                produced = 1'b1;
                seq_acc  = '0;
            end
        end else if (!b[7]) begin
            cp       = CP_W'(b);
            produced = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            seq_acc  = CP_W'(b & PAY2_MASK);
            seq_left = REM_ONE;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            seq_acc  = CP_W'(b & PAY3_MASK);
            seq_left = REM_TWO;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            seq_acc  = CP_W'(b & PAY4_MASK);
            seq_left = REM_THREE;
        end else begin
            lead_ok = 1'b0;
        end

        if (last) begin
            // report a sequence cut short as it stands; a bad lead gives no value
            if (!produced && lead_ok) begin
                cp       = seq_acc;
                produced = 1'b1;
            end
            queue_result('{cp: produced ? cp : '0, has: produced, eos: 1'b1});
            seq_acc  = '0;
            seq_left = REM_NONE;
        end else if (produced) begin
            queue_result('{cp: cp, has: 1'b1, eos: 1'b0});
        end
    endfunction

    // Send one byte request, with a random lead-in gap, and predict its result.
    // Return in the time step of the handshake, with tvalid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    // Send the collected bytes; mark the last one final if asked.
    task automatic send_text(input logic terminate);
        foreach (text_bytes[i])
            send_byte(text_bytes[i], terminate && (i == text_bytes.size() - 1));
        text_bytes.delete();
    endtask

    // Drop tvalid and hold the sender until every predicted result has come.
    // Call only right after a send, so tvalid sees one update in this step.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_code_points.size() != 0);
    endtask

    // Compare one result request against the oldest prediction.
    task automatic check_result();
        t_cp_result want;
        if (pending_code_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: cp=%06h has=%b eos=%b",
                         m_tdata[CP_W-1:0], m_tuser[0], m_tlast);
        end else begin
            want = pending_code_points.pop_front();
            if (m_tdata[CP_W-1:0] !== want.cp || m_tuser[0] !== want.has
                    || m_tlast !== want.eos) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"mismatch: expected cp=%06h has=%b eos=%b,",
                              " got cp=%06h has=%b eos=%b"},
                             want.cp, want.has, want.eos,
                             m_tdata[CP_W-1:0], m_tuser[0], m_tlast);
            end
        end
    endtask

    // Sink side: draw a stall before each result, then accept and check it.
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = recv_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            check_result();
        end
    end

    // Watchdog: end a hung run.
    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // ASCII at both ends of its range, then a plain character as final byte.
    task automatic test_ascii_extremes();
        text_bytes = '{8'h00, 8'h7F, 8'h41};
        send_text(1'b1);
    endtask

    // Largest payload for each sequence length, plus an overlong zero.
    task automatic test_multibyte_sequences();
        text_bytes = '{8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC0, 8'h80};
        send_text(1'b0);
    endtask

    // Continuations without the 10xxxxxx marker are still shifted in.
    task automatic test_lenient_continuation();
        text_bytes = '{8'hE0, 8'h41, 8'hFF};
        send_text(1'b0);
    endtask

    // Bad lead bytes are skipped; a bad lead as final byte reports no value.
    task automatic test_invalid_leads();
        text_bytes = '{8'h80, 8'hFF, 8'hF8, 8'hBF};
        send_text(1'b1);
    endtask

    // Sequence cut short by the final byte, then a lead byte that is final.
    task automatic test_truncated_final();
        text_bytes = '{8'hE2, 8'h82};
        send_text(1'b1);
        wait_for_results();
        text_bytes = '{8'hF4};
        send_text(1'b1);
    endtask

    // Mostly well-formed strings with random content; some broken and noise.
    task automatic test_random_text();
        int          mode;
        int          strings;
        int          kind;
        int          cut;
        logic [31:0] rnd;
        strings = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            // leave some strings with no gaps on one side or both
            send_gaps_on   = ($urandom_range(0, 3) != 0);
            recv_stalls_on = ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 9);
            if (mode <= 7) begin
                repeat ($urandom_range(1, 12)) begin
                    kind = $urandom_range(1, 4);
                    rnd  = $urandom;
                    case (kind)
                        1: append_text_byte({1'b0, rnd[6:0]});
                        2: append_text_byte({3'b110, rnd[4:0]});
                        3: append_text_byte({4'b1110, rnd[3:0]});
                        default: append_text_byte({5'b11110, rnd[2:0]});
                    endcase
                    for (int k = 1; k < kind; k++) begin
                        rnd = $urandom;
                        append_text_byte({2'b10, rnd[5:0]});
                    end
                end
                if (mode == 7) begin
                    // break the string: cut it short and corrupt one byte
                    cut = $urandom_range(1, text_bytes.size());
                    while (text_bytes.size() > cut)
                        void'(text_bytes.pop_back());
                    text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
                end
            end else if (mode == 8) begin
                repeat ($urandom_range(1, 10))
                    append_text_byte(8'($urandom));
            end else begin
                append_text_byte(8'($urandom));
            end
            // noise may run on unterminated and carry state into the next string
            send_text(mode != 8 || $urandom_range(0, 1) == 1);
            strings++;
            if (strings % 40 == 0)
                wait_for_results();
        end
    endtask

    initial begin : main
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ascii_extremes();
        test_multibyte_sequences();
        test_lenient_continuation();
        test_invalid_leads();
        test_truncated_final();
        test_random_text();

        // drain, then give the pipeline time to show any stray result
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_code_points.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
